[design/wrlm_pkg.sv]
// ----------------------------------------------------------------------------
// wrlm_pkg: shared types and codes for the water risk level monitor
// Event kinds, risk level codes, register indexes, reset values and the
// structs that run between the front end, the back end and the register file.
// ----------------------------------------------------------------------------
package wrlm_pkg;

   // register file geometry
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int THR_BITS       = 12;
   localparam int INTERVAL_BITS  = 32;

   // event kinds
   localparam logic [1:0] KIND_SAMPLE  = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_ACTUATE = 2'd2;

   // risk levels
   localparam logic [1:0] LEVEL_SAFE    = 2'd0;
   localparam logic [1:0] LEVEL_WARNING = 2'd1;
   localparam logic [1:0] LEVEL_ALERT   = 2'd2;
   localparam logic [1:0] LEVEL_DANGER  = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WARNING_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALERT_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DANGER_THRESHOLD  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_OFFSET       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNTS_PER_CM     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPORT_INTERVAL   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TIME         = 3'd6;

   // register reset values
   localparam logic [THR_BITS-1:0]      RST_WARNING_THRESHOLD = 12'd1024;
   localparam logic [THR_BITS-1:0]      RST_ALERT_THRESHOLD   = 12'd2048;
   localparam logic [THR_BITS-1:0]      RST_DANGER_THRESHOLD  = 12'd3072;
   localparam logic [THR_BITS-1:0]      RST_ZERO_OFFSET       = 12'd0;
   localparam logic [THR_BITS-1:0]      RST_COUNTS_PER_CM     = 12'd16;
   localparam logic [INTERVAL_BITS-1:0] RST_REPORT_INTERVAL   = 32'd60000;
   localparam logic [INTERVAL_BITS-1:0] RST_HOLD_TIME         = 32'd30000;

   // thresholds used by the front end
   typedef struct packed {
      logic [THR_BITS-1:0] warning;
      logic [THR_BITS-1:0] alert;
      logic [THR_BITS-1:0] danger;
   } wrlm_thr_type;

   // calibration and timing used by the back end
   typedef struct packed {
      logic [THR_BITS-1:0]      zero_offset;
      logic [THR_BITS-1:0]      counts_per_cm;
      logic [INTERVAL_BITS-1:0] report_interval_ms;
      logic [INTERVAL_BITS-1:0] hold_time_ms;
   } wrlm_cal_type;

   // decoded event, as queued between front and back
   typedef struct packed {
      logic       is_sample;
      logic       is_actuate;
      logic [1:0] class_level;
   } wrlm_ctl_type;

endpackage

[design/wrlm_front.sv]
// ----------------------------------------------------------------------------
// wrlm_front: event intake and classification
// Decodes the event kind and classifies the sample against the three
// thresholds, then pushes the decoded beat into the queue.
// ----------------------------------------------------------------------------
module wrlm_front #(
   parameter int SAMPLE_BITS = 12,
   parameter int TIME_BITS   = 48
) (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic [TIME_BITS-1:0]      req_now_ms,
   input  wrlm_pkg::wrlm_thr_type    thr,
   input  logic                      q_full,
   output logic                      push,
   output wrlm_pkg::wrlm_ctl_type    push_ctl,
   output logic [SAMPLE_BITS-1:0]    push_sample,
   output logic [TIME_BITS-1:0]      push_now_ms
);

   localparam int CW = (SAMPLE_BITS > wrlm_pkg::THR_BITS) ? SAMPLE_BITS : wrlm_pkg::THR_BITS;

   logic [CW-1:0] s_ext;
   logic [1:0]    class_level;

   assign s_ext = CW'(req_sample);

   always_comb begin
      if (s_ext >= CW'(thr.danger)) begin
         class_level = wrlm_pkg::LEVEL_DANGER;
      end else if (s_ext >= CW'(thr.alert)) begin
         class_level = wrlm_pkg::LEVEL_ALERT;
      end else if (s_ext >= CW'(thr.warning)) begin
         class_level = wrlm_pkg::LEVEL_WARNING;
      end else begin
         class_level = wrlm_pkg::LEVEL_SAFE;
      end
   end

   always_comb begin
      push_ctl             = '0;
      push_ctl.class_level = class_level;
      case (req_kind)
         wrlm_pkg::KIND_SAMPLE: begin
            push_ctl.is_sample = 1'b1;
         end
         wrlm_pkg::KIND_ACTUATE: begin
            push_ctl.is_actuate = 1'b1;
         end
         wrlm_pkg::KIND_TICK: begin
            push_ctl.is_sample = 1'b0;
         end
         default: begin
            // unused kind re-evaluates like a tick
            push_ctl.is_sample = 1'b0;
         end
      endcase
   end

   assign req_stall   = q_full;
   assign push        = req_valid && !q_full;
   assign push_sample = req_sample;
   assign push_now_ms = req_now_ms;

endmodule

[design/wrlm_queue.sv]
// ----------------------------------------------------------------------------
// wrlm_queue: two-entry queue between front and back
// Plain FIFO of decoded beats; lets intake run ahead of the back end.
// ----------------------------------------------------------------------------
module wrlm_queue #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/wrlm_back.sv]
// ----------------------------------------------------------------------------
// wrlm_back: event execution
// Updates hold and report state, resolves the effective level and power cut,
// runs a restoring divide for the depth and holds the result beat.
// ----------------------------------------------------------------------------
module wrlm_back #(
   parameter int SAMPLE_BITS = 12,
   parameter int TIME_BITS   = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wrlm_pkg::wrlm_cal_type    cal,
   input  logic                      q_not_empty,
   output logic                      pop,
   input  wrlm_pkg::wrlm_ctl_type    pop_ctl,
   input  logic [SAMPLE_BITS-1:0]    pop_sample,
   input  logic [TIME_BITS-1:0]      pop_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_risk_level,
   output logic                      rsp_report_water,
   output logic [15:0]               rsp_level_sixteenths,
   output logic                      rsp_cut_power
);

   localparam int TB       = wrlm_pkg::THR_BITS;
   localparam int CW       = (SAMPLE_BITS > TB) ? SAMPLE_BITS : TB;
   localparam int N        = CW + 4;
   localparam int CNT_BITS = $clog2(N);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LEVEL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type              state_ff;
   wrlm_pkg::wrlm_ctl_type cur_ctl_ff;
   logic [SAMPLE_BITS-1:0] cur_sample_ff;
   logic [TIME_BITS-1:0]   cur_now_ff;

   logic [1:0]             sampled_level_ff;
   logic [1:0]             previous_level_ff;
   logic [TIME_BITS-1:0]   hold_until_ff;
   logic [TIME_BITS-1:0]   last_report_ff;

   logic                   report_ff;
   logic                   div_go_ff;
   logic [1:0]             eff_level_ff;
   logic                   cut_ff;
   logic [TB-1:0]          rem_ff;
   logic [N-1:0]           quo_ff;
   logic [CNT_BITS-1:0]    div_cnt_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_risk_level_ff;
   logic                   rsp_report_water_ff;
   logic [15:0]            rsp_level_sixteenths_ff;
   logic                   rsp_cut_power_ff;

   logic [TIME_BITS:0]     hold_sum;
   logic [TIME_BITS-1:0]   hold_end;
   logic [TIME_BITS:0]     since_diff;
   logic                   report_due;
   logic [CW-1:0]          s_ext;
   logic [CW-1:0]          zoff_ext;
   logic                   above_zero;
   logic [CW-1:0]          depth_raw;
   logic [TB-1:0]          divisor;
   logic [TB:0]            rem_shift;
   logic                   rem_ge;
   logic [TB:0]            rem_sub;
   logic [TB-1:0]          rem_next;
   logic [1:0]             eff_level;
   logic                   out_free;
   logic [15:0]            depth_sat;

   // hold end, saturating at the top of the time range
   assign hold_sum   = (TIME_BITS+1)'(cur_now_ff) + (TIME_BITS+1)'(cal.hold_time_ms);
   assign hold_end   = hold_sum[TIME_BITS] ? '1 : hold_sum[TIME_BITS-1:0];

   // report due: time not gone backwards and the interval has passed
   assign since_diff = (TIME_BITS+1)'(cur_now_ff) - (TIME_BITS+1)'(last_report_ff);
   assign report_due = !since_diff[TIME_BITS]
                    && (since_diff[TIME_BITS-1:0] >= TIME_BITS'(cal.report_interval_ms));

   assign s_ext      = CW'(cur_sample_ff);
   assign zoff_ext   = CW'(cal.zero_offset);
   assign above_zero = s_ext > zoff_ext;
   assign depth_raw  = s_ext - zoff_ext;

   // zero scale is taken as one
   assign divisor    = (cal.counts_per_cm == '0) ? TB'(1) : cal.counts_per_cm;

   // one restoring divide step
   assign rem_shift  = {rem_ff, quo_ff[N-1]};
   assign rem_ge     = rem_shift >= {1'b0, divisor};
   assign rem_sub    = rem_shift - {1'b0, divisor};
   assign rem_next   = rem_ge ? rem_sub[TB-1:0] : rem_shift[TB-1:0];

   assign depth_sat  = ((quo_ff >> 16) != '0) ? 16'hFFFF : quo_ff[15:0];

   assign eff_level  = (cur_now_ff < hold_until_ff) ? wrlm_pkg::LEVEL_DANGER
                                                    : sampled_level_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pop        = (state_ff == ST_IDLE) && q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         sampled_level_ff  <= wrlm_pkg::LEVEL_SAFE;
         previous_level_ff <= wrlm_pkg::LEVEL_SAFE;
         hold_until_ff     <= '0;
         last_report_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         // ST_OUT loads or keeps the beat itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_not_empty) begin
                  cur_ctl_ff    <= pop_ctl;
                  cur_sample_ff <= pop_sample;
                  cur_now_ff    <= pop_now_ms;
                  state_ff      <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               report_ff  <= cur_ctl_ff.is_sample && report_due;
               div_go_ff  <= cur_ctl_ff.is_sample && report_due && above_zero;
               quo_ff     <= {depth_raw, 4'b0000};
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               if (cur_ctl_ff.is_actuate) begin
                  hold_until_ff <= hold_end;
               end
               if (cur_ctl_ff.is_sample) begin
                  sampled_level_ff <= cur_ctl_ff.class_level;
                  if (report_due) begin
                     last_report_ff <= cur_now_ff;
                  end
               end
               state_ff <= ST_LEVEL;
            end
            ST_LEVEL: begin
               eff_level_ff      <= eff_level;
               cut_ff            <= (eff_level == wrlm_pkg::LEVEL_DANGER)
                                 && (previous_level_ff != wrlm_pkg::LEVEL_DANGER);
               previous_level_ff <= eff_level;
               state_ff          <= (report_ff && div_go_ff) ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
               rem_ff     <= rem_next;
               quo_ff     <= {quo_ff[N-2:0], rem_ge};
               div_cnt_ff <= div_cnt_ff + CNT_BITS'(1);
               if (div_cnt_ff == CNT_BITS'(N-1)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_risk_level_ff       <= eff_level_ff;
                  rsp_cut_power_ff        <= cut_ff;
                  rsp_report_water_ff     <= report_ff;
                  rsp_level_sixteenths_ff <= (report_ff && div_go_ff) ? depth_sat : 16'd0;
                  state_ff                <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_risk_level       = rsp_risk_level_ff;
   assign rsp_report_water     = rsp_report_water_ff;
   assign rsp_level_sixteenths = rsp_level_sixteenths_ff;
   assign rsp_cut_power        = rsp_cut_power_ff;

endmodule

[design/water_risk_level_monitor_unit.sv]
// ----------------------------------------------------------------------------
// water_risk_level_monitor_unit: water risk level monitor, top level
// Register file, event intake, two-entry queue and execution back end.
// ----------------------------------------------------------------------------
// Each req beat is one timestamped event (water sample, tick or actuation
// command) and yields exactly one rsp beat: the effective risk level, a power
// cut flag on each entry into danger, and a rate-limited water report with the
// depth in 1/16 cm (zero when no report is due). The front end classifies the
// sample on the way in and parks the beat in a two-entry queue, so up to two
// events are taken while the back end is busy or the rsp side stalls. The back
// end handles one event at a time: it pops the event, updates the state,
// resolves the level and then loads the output register, waiting there while
// the rsp side stalls; a sample whose report is due and whose reading is above
// zero_offset adds a restoring divide, one quotient bit per cycle, before the
// load. Registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module water_risk_level_monitor_unit #(
   parameter int TIME_BITS   = 48,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // event channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_kind,
   input  logic [SAMPLE_BITS-1:0]               req_sample,
   input  logic [TIME_BITS-1:0]                 req_now_ms,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_risk_level,
   output logic                                 rsp_report_water,
   output logic [15:0]                          rsp_level_sixteenths,
   output logic                                 rsp_cut_power,
   // register write port
   input  logic                                 csr_we,
   input  logic [wrlm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wrlm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CTL_BITS = $bits(wrlm_pkg::wrlm_ctl_type);
   localparam int Q_WIDTH  = CTL_BITS + SAMPLE_BITS + TIME_BITS;
   localparam int TB       = wrlm_pkg::THR_BITS;
   localparam int IB       = wrlm_pkg::INTERVAL_BITS;

   // register file
   logic [TB-1:0] warning_ff;
   logic [TB-1:0] alert_ff;
   logic [TB-1:0] danger_ff;
   logic [TB-1:0] zero_offset_ff;
   logic [TB-1:0] counts_per_cm_ff;
   logic [IB-1:0] report_interval_ff;
   logic [IB-1:0] hold_time_ff;

   wrlm_pkg::wrlm_thr_type thr;
   wrlm_pkg::wrlm_cal_type cal;

   // front to queue
   logic                   push;
   wrlm_pkg::wrlm_ctl_type push_ctl;
   logic [SAMPLE_BITS-1:0] push_sample;
   logic [TIME_BITS-1:0]   push_now_ms;
   logic                   q_full;

   // queue to back
   logic                   pop;
   logic                   q_not_empty;
   logic [Q_WIDTH-1:0]     pop_data;
   wrlm_pkg::wrlm_ctl_type pop_ctl;
   logic [SAMPLE_BITS-1:0] pop_sample;
   logic [TIME_BITS-1:0]   pop_now_ms;

   // writes to an unlisted index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         warning_ff         <= wrlm_pkg::RST_WARNING_THRESHOLD;
         alert_ff           <= wrlm_pkg::RST_ALERT_THRESHOLD;
         danger_ff          <= wrlm_pkg::RST_DANGER_THRESHOLD;
         zero_offset_ff     <= wrlm_pkg::RST_ZERO_OFFSET;
         counts_per_cm_ff   <= wrlm_pkg::RST_COUNTS_PER_CM;
         report_interval_ff <= wrlm_pkg::RST_REPORT_INTERVAL;
         hold_time_ff       <= wrlm_pkg::RST_HOLD_TIME;
      end else if (csr_we) begin
         case (csr_index)
            wrlm_pkg::CSR_WARNING_THRESHOLD: warning_ff         <= csr_wdata[TB-1:0];
            wrlm_pkg::CSR_ALERT_THRESHOLD:   alert_ff           <= csr_wdata[TB-1:0];
            wrlm_pkg::CSR_DANGER_THRESHOLD:  danger_ff          <= csr_wdata[TB-1:0];
            wrlm_pkg::CSR_ZERO_OFFSET:       zero_offset_ff     <= csr_wdata[TB-1:0];
            wrlm_pkg::CSR_COUNTS_PER_CM:     counts_per_cm_ff   <= csr_wdata[TB-1:0];
            wrlm_pkg::CSR_REPORT_INTERVAL:   report_interval_ff <= csr_wdata[IB-1:0];
            wrlm_pkg::CSR_HOLD_TIME:         hold_time_ff       <= csr_wdata[IB-1:0];
            default: begin
            end
         endcase
      end
   end

   assign thr.warning            = warning_ff;
   assign thr.alert              = alert_ff;
   assign thr.danger             = danger_ff;
   assign cal.zero_offset        = zero_offset_ff;
   assign cal.counts_per_cm      = counts_per_cm_ff;
   assign cal.report_interval_ms = report_interval_ff;
   assign cal.hold_time_ms       = hold_time_ff;

   // intake: decode and classify
   wrlm_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_sample  (req_sample),
      .req_now_ms  (req_now_ms),
      .thr         (thr),
      .q_full      (q_full),
      .push        (push),
      .push_ctl    (push_ctl),
      .push_sample (push_sample),
      .push_now_ms (push_now_ms)
   );

   // decoupling queue
   wrlm_queue #(
      .WIDTH (Q_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_sample, push_now_ms}),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   assign pop_ctl    = pop_data[Q_WIDTH-1 -: CTL_BITS];
   assign pop_sample = pop_data[TIME_BITS +: SAMPLE_BITS];
   assign pop_now_ms = pop_data[TIME_BITS-1:0];

   // execution: state update, level, divide, output register
   wrlm_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cal                  (cal),
      .q_not_empty          (q_not_empty),
      .pop                  (pop),
      .pop_ctl              (pop_ctl),
      .pop_sample           (pop_sample),
      .pop_now_ms           (pop_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_risk_level       (rsp_risk_level),
      .rsp_report_water     (rsp_report_water),
      .rsp_level_sixteenths (rsp_level_sixteenths),
      .rsp_cut_power        (rsp_cut_power)
   );

endmodule

[design/wrlm_checker.sv]
// ----------------------------------------------------------------------------
// wrlm_checker: port-level checks for the water risk level monitor
// Watches the result channel and flags protocol or consistency slips.
// ----------------------------------------------------------------------------
module wrlm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_risk_level,
   input logic        rsp_report_water,
   input logic [15:0] rsp_level_sixteenths,
   input logic        rsp_cut_power
);

   // a stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // a stalled beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_risk_level) && $stable(rsp_report_water)
         && $stable(rsp_level_sixteenths) && $stable(rsp_cut_power))
      else $error("rsp payload changed while stalled");

   // depth only travels with a report
   a_depth_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_water |-> rsp_level_sixteenths == 16'd0)
      else $error("depth nonzero without a report");

   // power cut only on a danger level
   a_cut_danger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cut_power |-> rsp_risk_level == wrlm_pkg::LEVEL_DANGER)
      else $error("power cut without danger level");

endmodule

bind water_risk_level_monitor_unit wrlm_checker u_wrlm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_risk_level       (rsp_risk_level),
   .rsp_report_water     (rsp_report_water),
   .rsp_level_sixteenths (rsp_level_sixteenths),
   .rsp_cut_power        (rsp_cut_power)
);
